/* design/pts_pkg.sv */
// Shared types, token codes and the keyword table of the PL/0 token scanner.
`default_nettype none

package pts_pkg;

	// Fixed field geometry of a result item.
	localparam int NAME_SLOTS = 11;
	localparam int KW_CHARS   = 9;
	localparam int KW_COUNT   = 13;

	// Defaults for the top-level parameters.
	localparam int MAX_NAME_CHARS_DEF    = 11;
	localparam int MAX_NUMBER_DIGITS_DEF = 5;
	localparam int QUEUE_DEPTH_DEF       = 4;

	// Token codes.
	localparam logic [5:0] TOK_END     = 6'd0;
	localparam logic [5:0] TOK_IDENT   = 6'd2;
	localparam logic [5:0] TOK_NUMBER  = 6'd3;
	localparam logic [5:0] TOK_PLUS    = 6'd4;
	localparam logic [5:0] TOK_MINUS   = 6'd5;
	localparam logic [5:0] TOK_TIMES   = 6'd6;
	localparam logic [5:0] TOK_SLASH   = 6'd7;
	localparam logic [5:0] TOK_EQL     = 6'd9;
	localparam logic [5:0] TOK_NEQ     = 6'd10;
	localparam logic [5:0] TOK_LSS     = 6'd11;
	localparam logic [5:0] TOK_LEQ     = 6'd12;
	localparam logic [5:0] TOK_GTR     = 6'd13;
	localparam logic [5:0] TOK_GEQ     = 6'd14;
	localparam logic [5:0] TOK_LPAREN  = 6'd15;
	localparam logic [5:0] TOK_RPAREN  = 6'd16;
	localparam logic [5:0] TOK_COMMA   = 6'd17;
	localparam logic [5:0] TOK_SEMI    = 6'd18;
	localparam logic [5:0] TOK_PERIOD  = 6'd19;
	localparam logic [5:0] TOK_BECOMES = 6'd20;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NAME_LONG = 3'd1;
	localparam logic [2:0] ERR_NUM_LONG  = 3'd2;
	localparam logic [2:0] ERR_SYMBOL    = 3'd3;
	localparam logic [2:0] ERR_COLON     = 3'd4;

	// Keywords, each right-aligned so that its first character is its top byte.
	localparam logic [8*KW_CHARS-1:0] KW_WORD [KW_COUNT] = '{
		"odd", "begin", "end", "if", "then", "while", "do", "call",
		"const", "var", "procedure", "write", "read"
	};
	localparam int KW_LEN [KW_COUNT] = '{3, 5, 3, 2, 4, 5, 2, 4, 5, 3, 9, 5, 4};
	localparam logic [5:0] KW_CODE [KW_COUNT] = '{
		6'd1, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd32
	};

	// How the back end turns a result descriptor into a result item.
	typedef enum logic [1:0] {
		RK_TOK,
		RK_NAME,
		RK_NUM,
		RK_ERR
	} res_kind_t;

	typedef struct packed {
		res_kind_t  kind;
		logic [5:0] code;
		logic [2:0] err;
	} pts_res_t;

	// One queue entry: the results of one input item and the token text they need.
	typedef struct packed {
		pts_res_t                        res0;
		pts_res_t                        res1;
		logic                            two;
		logic [NAME_SLOTS-1:0][7:0]      chars;
		logic [3:0]                      len;
		logic [16:0]                     num;
	} pts_entry_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic avail;
	} pts_qstat_t;

	// Returns the keyword code of a name, or TOK_END when it is no keyword.
	function automatic logic [5:0] kw_lookup(input logic [NAME_SLOTS-1:0][7:0] chars,
			input logic [3:0] len);
		logic [5:0] code;
		logic       match;
		code = TOK_END;
		for (int k = 0; k < KW_COUNT; k++) begin
			match = (len == 4'(KW_LEN[k]));
			for (int i = 0; i < KW_CHARS; i++) begin
				if (i < KW_LEN[k]) begin
					if (chars[i] != KW_WORD[k][8*(KW_LEN[k]-1-i) +: 8]) begin
						match = 1'b0;
					end
				end
			end
			if (match) begin
				code = KW_CODE[k];
			end
		end
		return code;
	endfunction

endpackage

`default_nettype wire

/* design/pts_if.sv */
// Valid/ready channel interfaces for source bytes and result items.
`default_nettype none

interface pts_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_code;

	modport source(output valid, output req_type, output char_code, input ready);
	modport sink(input valid, input req_type, input char_code, output ready);
endinterface

interface pts_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_code;
	logic [16:0] number_value;
	logic [63:0] name_head;
	logic [23:0] name_tail;
	logic [3:0]  name_length;
	logic [2:0]  error_code;
	logic        last_in_run;

	modport source(output valid, output token_code, output number_value, output name_head,
		output name_tail, output name_length, output error_code, output last_in_run,
		input ready);
	modport sink(input valid, input token_code, input number_value, input name_head,
		input name_tail, input name_length, input error_code, input last_in_run,
		output ready);
endinterface

`default_nettype wire

/* design/pts_queue.sv */
// Short register queue between the scanner front end and the result formatter.
`default_nettype none

module pts_queue #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] push_data,
	input  wire logic             pop,
	output pts_pkg::pts_qstat_t   stat,
	output logic [Width-1:0]      head
);
	import pts_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] slot_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	// Status and head of the queue.
	always_comb begin
		stat.full  = (count_q == CntW'(Depth));
		stat.avail = (count_q != '0);
		head       = slot_q[rd_ptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	// The front end never writes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && stat.full))
		else $error("queue written while full");
	// The back end never takes from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !stat.avail))
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* design/pts_front.sv */
// Scanner front end: takes source bytes, tracks the lexical state, queues results.
`default_nettype none

module pts_front #(
	parameter int MaxNameChars    = pts_pkg::MAX_NAME_CHARS_DEF,
	parameter int MaxNumberDigits = pts_pkg::MAX_NUMBER_DIGITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	pts_in_if.sink              text,
	input  pts_pkg::pts_qstat_t qstat,
	output logic                push,
	output pts_pkg::pts_entry_t entry
);
	import pts_pkg::*;

	localparam int NameIdxW = $clog2(MaxNameChars);

	typedef enum logic [3:0] {
		M_IDLE,
		M_NAME,
		M_NUMBER,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_BLOCK_STAR,
		M_LESS,
		M_GREATER,
		M_COLON,
		M_HALT
	} mode_t;

	typedef struct packed {
		mode_t    mode;
		logic     emit;
		pts_res_t res;
		logic     start_name;
		logic     start_num;
	} idle_res_t;

	mode_t       mode_q;
	logic [7:0]  name_q [MaxNameChars];
	logic [3:0]  count_q;
	logic [16:0] num_q;
	logic [2:0]  digits_q;

	logic        accept;
	logic [7:0]  c;
	mode_t       nmode;
	idle_res_t   iv;
	logic        use_idle;
	logic        pend_v;
	pts_res_t    pend;
	logic        end_v;
	logic        wr_char;
	logic        wr_digit;
	logic        end_clear;
	logic        idle_emit;
	logic [3:0]  digit_val;

	function automatic pts_res_t mk(input res_kind_t kind, input logic [5:0] code,
			input logic [2:0] err);
		pts_res_t r;
		r.kind = kind;
		r.code = code;
		r.err  = err;
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] ch);
		return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= "0" && ch <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
	endfunction

	// What a byte does when no token is pending.
	function automatic idle_res_t idle_eval(input logic [7:0] ch);
		idle_res_t r;
		r.mode       = M_IDLE;
		r.emit       = 1'b0;
		r.res        = mk(RK_TOK, TOK_END, ERR_NONE);
		r.start_name = 1'b0;
		r.start_num  = 1'b0;
		if (is_space(ch)) begin
			r.mode = M_IDLE;
		end else if (is_letter(ch)) begin
			r.mode       = M_NAME;
			r.start_name = 1'b1;
		end else if (is_digit(ch)) begin
			r.mode      = M_NUMBER;
			r.start_num = 1'b1;
		end else begin
			r.emit = 1'b1;
			case (ch)
				"+": r.res = mk(RK_TOK, TOK_PLUS, ERR_NONE);
				"-": r.res = mk(RK_TOK, TOK_MINUS, ERR_NONE);
				"*": r.res = mk(RK_TOK, TOK_TIMES, ERR_NONE);
				"=": r.res = mk(RK_TOK, TOK_EQL, ERR_NONE);
				"(": r.res = mk(RK_TOK, TOK_LPAREN, ERR_NONE);
				")": r.res = mk(RK_TOK, TOK_RPAREN, ERR_NONE);
				",": r.res = mk(RK_TOK, TOK_COMMA, ERR_NONE);
				";": r.res = mk(RK_TOK, TOK_SEMI, ERR_NONE);
				".": r.res = mk(RK_TOK, TOK_PERIOD, ERR_NONE);
				"/": begin
					r.emit = 1'b0;
					r.mode = M_SLASH;
				end
				"<": begin
					r.emit = 1'b0;
					r.mode = M_LESS;
				end
				">": begin
					r.emit = 1'b0;
					r.mode = M_GREATER;
				end
				":": begin
					r.emit = 1'b0;
					r.mode = M_COLON;
				end
				default: begin
					r.res  = mk(RK_ERR, TOK_END, ERR_SYMBOL);
					r.mode = M_HALT;
				end
			endcase
		end
		return r;
	endfunction

	assign text.ready = !qstat.full;
	assign accept     = text.valid && text.ready;
	assign c          = text.char_code;
	assign digit_val  = 4'(c - "0");

	// Next lexical state and the results this item causes.
	always_comb begin
		nmode     = mode_q;
		iv        = idle_eval(c);
		use_idle  = 1'b0;
		pend_v    = 1'b0;
		pend      = mk(RK_TOK, TOK_END, ERR_NONE);
		end_v     = 1'b0;
		wr_char   = 1'b0;
		wr_digit  = 1'b0;
		end_clear = 1'b0;
		if (mode_q != M_HALT) begin
			if (text.req_type) begin
				// End of text: flush the pending token, then the end marker; a pending colon instead halts on its error.
				case (mode_q)
					M_NAME: begin
						pend_v = 1'b1;
						pend   = mk(RK_NAME, TOK_IDENT, ERR_NONE);
					end
					M_NUMBER: begin
						pend_v = 1'b1;
						pend   = mk(RK_NUM, TOK_NUMBER, ERR_NONE);
					end
					M_SLASH: begin
						pend_v = 1'b1;
						pend   = mk(RK_TOK, TOK_SLASH, ERR_NONE);
					end
					M_LESS: begin
						pend_v = 1'b1;
						pend   = mk(RK_TOK, TOK_LSS, ERR_NONE);
					end
					M_GREATER: begin
						pend_v = 1'b1;
						pend   = mk(RK_TOK, TOK_GTR, ERR_NONE);
					end
					M_COLON: begin
						pend_v = 1'b1;
						pend   = mk(RK_ERR, TOK_END, ERR_COLON);
					end
					default: ;
				endcase
				if (mode_q == M_COLON) begin
					nmode = M_HALT;
				end else begin
					end_v     = 1'b1;
					end_clear = 1'b1;
					nmode     = M_IDLE;
				end
			end else begin
				case (mode_q)
					M_NAME: begin
						if (is_letter(c) || is_digit(c)) begin
							if (count_q < 4'(MaxNameChars)) begin
								wr_char = 1'b1;
							end else begin
								pend_v = 1'b1;
								pend   = mk(RK_ERR, TOK_END, ERR_NAME_LONG);
								nmode  = M_HALT;
							end
						end else begin
							pend_v   = 1'b1;
							pend     = mk(RK_NAME, TOK_IDENT, ERR_NONE);
							use_idle = 1'b1;
						end
					end
					M_NUMBER: begin
						if (is_digit(c)) begin
							if (digits_q < 3'(MaxNumberDigits)) begin
								wr_digit = 1'b1;
							end else begin
								pend_v = 1'b1;
								pend   = mk(RK_ERR, TOK_END, ERR_NUM_LONG);
								nmode  = M_HALT;
							end
						end else begin
							pend_v   = 1'b1;
							pend     = mk(RK_NUM, TOK_NUMBER, ERR_NONE);
							use_idle = 1'b1;
						end
					end
					M_SLASH: begin
						if (c == "/") begin
							nmode = M_LINE;
						end else if (c == "*") begin
							nmode = M_BLOCK;
						end else begin
							pend_v   = 1'b1;
							pend     = mk(RK_TOK, TOK_SLASH, ERR_NONE);
							use_idle = 1'b1;
						end
					end
					M_LINE: begin
						if (c == 8'd10) begin
							nmode = M_IDLE;
						end
					end
					M_BLOCK: begin
						if (c == "*") begin
							nmode = M_BLOCK_STAR;
						end
					end
					M_BLOCK_STAR: begin
						if (c == "/") begin
							nmode = M_IDLE;
						end else if (c != "*") begin
							nmode = M_BLOCK;
						end
					end
					M_LESS: begin
						if (c == ">") begin
							pend_v = 1'b1;
							pend   = mk(RK_TOK, TOK_NEQ, ERR_NONE);
							nmode  = M_IDLE;
						end else if (c == "=") begin
							pend_v = 1'b1;
							pend   = mk(RK_TOK, TOK_LEQ, ERR_NONE);
							nmode  = M_IDLE;
						end else begin
							pend_v   = 1'b1;
							pend     = mk(RK_TOK, TOK_LSS, ERR_NONE);
							use_idle = 1'b1;
						end
					end
					M_GREATER: begin
						if (c == "=") begin
							pend_v = 1'b1;
							pend   = mk(RK_TOK, TOK_GEQ, ERR_NONE);
							nmode  = M_IDLE;
						end else begin
							pend_v   = 1'b1;
							pend     = mk(RK_TOK, TOK_GTR, ERR_NONE);
							use_idle = 1'b1;
						end
					end
					M_COLON: begin
						if (c == "=") begin
							pend_v = 1'b1;
							pend   = mk(RK_TOK, TOK_BECOMES, ERR_NONE);
							nmode  = M_IDLE;
						end else begin
							pend_v = 1'b1;
							pend   = mk(RK_ERR, TOK_END, ERR_COLON);
							nmode  = M_HALT;
						end
					end
					default: begin
						use_idle = 1'b1;
					end
				endcase
			end
		end
		if (use_idle) begin
			nmode = iv.mode;
		end
	end

	// Queue entry: at most a pending token and then a second result.
	always_comb begin
		idle_emit   = use_idle && iv.emit;
		push        = accept && (pend_v || idle_emit || end_v);
		entry.res0  = pend_v ? pend : (end_v ? mk(RK_TOK, TOK_END, ERR_NONE) : iv.res);
		entry.res1  = end_v ? mk(RK_TOK, TOK_END, ERR_NONE) : iv.res;
		entry.two   = pend_v && (idle_emit || end_v);
		entry.len   = count_q;
		entry.num   = num_q;
		entry.chars = '0;
		for (int i = 0; i < MaxNameChars; i++) begin
			entry.chars[i] = name_q[i];
		end
	end

	// Lexical state and token accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			count_q  <= '0;
			num_q    <= '0;
			digits_q <= '0;
		end else if (accept) begin
			mode_q <= nmode;
			if (end_clear) begin
				count_q  <= '0;
				num_q    <= '0;
				digits_q <= '0;
			end else if (use_idle && iv.start_name) begin
				count_q <= 4'd1;
			end else if (use_idle && iv.start_num) begin
				num_q    <= 17'(digit_val);
				digits_q <= 3'd1;
			end else if (wr_char) begin
				count_q <= count_q + 4'd1;
			end else if (wr_digit) begin
				num_q    <= {num_q[13:0], 3'b000} + {num_q[15:0], 1'b0} + 17'(digit_val);
				digits_q <= digits_q + 3'd1;
			end
		end
	end

	// Name characters, written before they are read.
	always_ff @(posedge clk) begin
		if (accept && use_idle && iv.start_name) begin
			name_q[0] <= c;
		end else if (accept && wr_char) begin
			name_q[count_q[NameIdxW-1:0]] <= c;
		end
	end

`ifndef SYNTH
	// Once halted, the scanner queues nothing until reset.
	assert property (@(posedge clk) disable iff (!arst_n) (mode_q == M_HALT) |-> !push)
		else $error("result queued while halted");
`endif

endmodule

`default_nettype wire

/* design/pts_back.sv */
// Scanner back end: turns queued descriptors into result items, one per cycle while the receiver is ready.
`default_nettype none

module pts_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  pts_pkg::pts_qstat_t qstat,
	input  pts_pkg::pts_entry_t entry,
	output logic                pop,
	pts_out_if.source           tokens
);
	import pts_pkg::*;

	typedef struct packed {
		logic [5:0]  code;
		logic [16:0] num;
		logic [63:0] head;
		logic [23:0] tail;
		logic [3:0]  len;
		logic [2:0]  err;
	} tok_fields_t;

	logic        phase_q;
	logic        out_valid_q;
	tok_fields_t out_q;
	logic        last_q;

	logic        load;
	logic        last;
	pts_res_t    sel;
	tok_fields_t f;

	// Expands one descriptor with the entry's token text.
	function automatic tok_fields_t fmt(input pts_res_t r, input pts_entry_t e);
		tok_fields_t o;
		logic [5:0]  kw;
		o  = '0;
		kw = kw_lookup(e.chars, e.len);
		case (r.kind)
			RK_TOK: o.code = r.code;
			RK_NUM: begin
				o.code = TOK_NUMBER;
				o.num  = e.num;
			end
			RK_ERR: o.err = r.err;
			RK_NAME: begin
				if (kw != TOK_END) begin
					o.code = kw;
				end else begin
					o.code = TOK_IDENT;
					o.len  = e.len;
					for (int i = 0; i < 8; i++) begin
						if (4'(i) < e.len) begin
							o.head[8*i +: 8] = e.chars[i];
						end
					end
					for (int i = 0; i < NAME_SLOTS - 8; i++) begin
						if (4'(i + 8) < e.len) begin
							o.tail[8*i +: 8] = e.chars[i + 8];
						end
					end
				end
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// Pick the descriptor of this phase and decide whether the entry is done.
	always_comb begin
		load = !out_valid_q || tokens.ready;
		sel  = phase_q ? entry.res1 : entry.res0;
		last = phase_q || !entry.two;
		pop  = load && qstat.avail && last;
		f    = fmt(sel, entry);
	end

	// Output register control and the phase within a two-result entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= qstat.avail;
			if (qstat.avail) begin
				phase_q <= !last;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load && qstat.avail) begin
			out_q  <= f;
			last_q <= last;
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.token_code   = out_q.code;
	assign tokens.number_value = out_q.num;
	assign tokens.name_head    = out_q.head;
	assign tokens.name_tail    = out_q.tail;
	assign tokens.name_length  = out_q.len;
	assign tokens.error_code   = out_q.err;
	assign tokens.last_in_run  = last_q;

`ifndef SYNTH
	// The second result of an entry is only pending while the entry is still queued.
	assert property (@(posedge clk) disable iff (!arst_n) phase_q |-> qstat.avail)
		else $error("second result pending without a queued entry");
	// An entry leaves the queue only when its last result enters the output register.
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> (out_valid_q && last_q))
		else $error("entry retired without its last result");
`endif

endmodule

`default_nettype wire

/* design/pl0_token_scanner.sv */
// PL/0 token scanner top level: front end, entry queue and result formatter.
//
// Usage: source text enters on the text channel one item per byte; req_type
// high marks end of text, which flushes a pending token and sends an end
// marker (token code 0). Results leave on the tokens channel; last_in_run is
// set on the final result caused by each input item, and an item causes zero,
// one or two results. Whitespace and comments cause no result.
// A result passes through the queue and the formatter's output register: the
// edge that accepts the item completing it writes the queue, and the output
// register loads it from the queue head once the formatter is free.
// Throughput: one input item per cycle as long as the queue has room; the
// formatter sends one result per cycle while the receiver is ready, so an item
// with two results sends them one after the other. The QueueDepth-entry queue absorbs those bursts.
// A lexical error sends one error result; after it every item is accepted
// and dropped until reset.
// Reset: the queue and output register empty, the scanner returns to its
// idle state. When the receiver stalls, the output holds, the queue fills,
// and text.ready falls once the queue is full.
`default_nettype none

module pl0_token_scanner #(
	parameter int MaxNameChars    = pts_pkg::MAX_NAME_CHARS_DEF,
	parameter int MaxNumberDigits = pts_pkg::MAX_NUMBER_DIGITS_DEF,
	parameter int QueueDepth      = pts_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pts_in_if.sink    text,
	pts_out_if.source tokens
);
	import pts_pkg::*;

	pts_qstat_t qstat;
	pts_entry_t push_entry;
	pts_entry_t head_entry;
	logic       push;
	logic       pop;

	pts_front #(
		.MaxNameChars    (MaxNameChars),
		.MaxNumberDigits (MaxNumberDigits)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.qstat  (qstat),
		.push   (push),
		.entry  (push_entry)
	);

	pts_queue #(
		.Width ($bits(pts_entry_t)),
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.stat      (qstat),
		.head      (head_entry)
	);

	pts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.entry  (head_entry),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

`default_nettype wire

/* bench/tb_pl0_token_scanner.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the PL/0 token scanner: random source text checked against a scanner model.
module tb_pl0_token_scanner;
	import pts_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int TEXT_ITEMS   = 650;
	localparam int CALM_TAIL    = 80;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 40;
	localparam int WORD_COUNT   = 13;
	localparam int SYMBOL_COUNT = 16;

	// Keyword token codes.
	localparam logic [5:0] TOK_KW_ODD       = 6'd1;
	localparam logic [5:0] TOK_KW_BEGIN     = 6'd21;
	localparam logic [5:0] TOK_KW_END       = 6'd22;
	localparam logic [5:0] TOK_KW_IF        = 6'd23;
	localparam logic [5:0] TOK_KW_THEN      = 6'd24;
	localparam logic [5:0] TOK_KW_WHILE     = 6'd25;
	localparam logic [5:0] TOK_KW_DO        = 6'd26;
	localparam logic [5:0] TOK_KW_CALL      = 6'd27;
	localparam logic [5:0] TOK_KW_CONST     = 6'd28;
	localparam logic [5:0] TOK_KW_VAR       = 6'd29;
	localparam logic [5:0] TOK_KW_PROCEDURE = 6'd30;
	localparam logic [5:0] TOK_KW_WRITE     = 6'd31;
	localparam logic [5:0] TOK_KW_READ      = 6'd32;

	// Request kinds of an input item.
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_EOT  = 1'b1;

	localparam logic [7:0] CH_NL = 8'd10;

	typedef struct packed {
		logic       req;
		logic [7:0] ch;
	} text_item_t;

	typedef struct packed {
		logic [5:0]  code;
		logic [16:0] num;
		logic [63:0] head;
		logic [23:0] tail;
		logic [3:0]  len;
		logic [2:0]  err;
		logic        last;
	} token_rec_t;

	typedef enum logic [3:0] {
		SM_IDLE, SM_NAME, SM_NUMBER, SM_SLASH, SM_LINE, SM_BLOCK, SM_BLOCK_STAR,
		SM_LESS, SM_GREATER, SM_COLON, SM_HALT
	} scan_mode_t;

	typedef enum int {PIECE_WORD, PIECE_NAME, PIECE_NUMBER, PIECE_SYMBOL} piece_kind_t;
	typedef enum int {FAULT_LONG_NAME, FAULT_LONG_NUMBER, FAULT_STRAY, FAULT_COLON} fault_kind_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pts_in_if  text_if ();
	pts_out_if tok_if ();

	logic       drv_valid  = 1'b0;
	logic       drv_req    = 1'b0;
	logic [7:0] drv_char   = 8'd0;
	logic       sink_ready = 1'b0;

	assign text_if.valid     = drv_valid;
	assign text_if.req_type  = drv_req;
	assign text_if.char_code = drv_char;
	assign tok_if.ready      = sink_ready;

	pl0_token_scanner u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.tokens (tok_if)
	);

	string kw_text [WORD_COUNT] = '{
		"odd", "begin", "end", "if", "then", "while", "do", "call",
		"const", "var", "procedure", "write", "read"
	};
	logic [5:0] kw_tok [WORD_COUNT] = '{
		TOK_KW_ODD, TOK_KW_BEGIN, TOK_KW_END, TOK_KW_IF, TOK_KW_THEN, TOK_KW_WHILE,
		TOK_KW_DO, TOK_KW_CALL, TOK_KW_CONST, TOK_KW_VAR, TOK_KW_PROCEDURE,
		TOK_KW_WRITE, TOK_KW_READ
	};
	string sym_text [SYMBOL_COUNT] = '{
		"+", "-", "*", "/", "=", "(", ")", ",", ";", ".", "<", ">", "<>", "<=", ">=", ":="
	};
	logic [7:0] ws_set [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

	text_item_t pending_bytes [$];
	token_rec_t want_tokens [$];
	token_rec_t step_out [$];

	// Scanner model state.
	scan_mode_t  scan_state = SM_IDLE;
	logic [7:0]  name_buf [MAX_NAME_CHARS_DEF];
	int          name_cnt  = 0;
	int unsigned num_acc   = 0;
	int          digit_cnt = 0;

	int fail_count = 0;
	int run_cycle  = 0;
	int feed_gap   = 0;
	int sink_gap   = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Character classes.
	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_punct(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "(" ||
			c == ")" || c == "," || c == ";" || c == "." || c == "<" || c == ">" || c == ":";
	endfunction

	// Result builders of the scanner model.
	task automatic emit_code(input logic [5:0] code);
		token_rec_t r;
		r = '0;
		r.code = code;
		step_out.push_back(r);
	endtask

	task automatic emit_error(input logic [2:0] err);
		token_rec_t r;
		r = '0;
		r.err = err;
		step_out.push_back(r);
		scan_state = SM_HALT;
	endtask

	task automatic emit_number();
		token_rec_t r;
		r = '0;
		r.code = TOK_NUMBER;
		r.num = num_acc[16:0];
		step_out.push_back(r);
	endtask

	// A finished name is either a keyword or an identifier packed into head and tail.
	task automatic emit_name();
		token_rec_t r;
		bit         hit;
		r = '0;
		for (int k = 0; k < WORD_COUNT; k++) begin
			if (kw_text[k].len() == name_cnt) begin
				hit = 1'b1;
				for (int i = 0; i < name_cnt; i++) begin
					if (kw_text[k][i] != name_buf[i]) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					emit_code(kw_tok[k]);
					return;
				end
			end
		end
		r.code = TOK_IDENT;
		r.len = 4'(name_cnt);
		for (int i = 0; i < name_cnt; i++) begin
			if (i < 8) begin
				r.head[8*i +: 8] = name_buf[i];
			end else begin
				r.tail[8*(i-8) +: 8] = name_buf[i];
			end
		end
		step_out.push_back(r);
	endtask

	// A byte seen with no token pending.
	task automatic idle_byte(input logic [7:0] c);
		scan_state = SM_IDLE;
		if (is_blank(c)) begin
			return;
		end
		if (is_alpha(c)) begin
			name_buf[0] = c;
			name_cnt = 1;
			scan_state = SM_NAME;
			return;
		end
		if (is_num(c)) begin
			num_acc = c - "0";
			digit_cnt = 1;
			scan_state = SM_NUMBER;
			return;
		end
		case (c)
			"+": emit_code(TOK_PLUS);
			"-": emit_code(TOK_MINUS);
			"*": emit_code(TOK_TIMES);
			"=": emit_code(TOK_EQL);
			"(": emit_code(TOK_LPAREN);
			")": emit_code(TOK_RPAREN);
			",": emit_code(TOK_COMMA);
			";": emit_code(TOK_SEMI);
			".": emit_code(TOK_PERIOD);
			"/": scan_state = SM_SLASH;
			"<": scan_state = SM_LESS;
			">": scan_state = SM_GREATER;
			":": scan_state = SM_COLON;
			default: emit_error(ERR_SYMBOL);
		endcase
	endtask

	// Advances the scanner model by one accepted item and queues the tokens it yields.
	task automatic scan_item(input logic req, input logic [7:0] c);
		token_rec_t r;
		step_out.delete();
		if (scan_state == SM_HALT) begin
			return;
		end
		if (req == REQ_EOT) begin
			case (scan_state)
				SM_NAME:    emit_name();
				SM_NUMBER:  emit_number();
				SM_SLASH:   emit_code(TOK_SLASH);
				SM_LESS:    emit_code(TOK_LSS);
				SM_GREATER: emit_code(TOK_GTR);
				SM_COLON:   emit_error(ERR_COLON);
				default: ;
			endcase
			if (scan_state != SM_HALT) begin
				emit_code(TOK_END);
				scan_state = SM_IDLE;
				name_cnt = 0;
				num_acc = 0;
				digit_cnt = 0;
			end
		end else begin
			case (scan_state)
				SM_NAME: begin
					if (is_alpha(c) || is_num(c)) begin
						if (name_cnt < MAX_NAME_CHARS_DEF) begin
							name_buf[name_cnt] = c;
							name_cnt++;
						end else begin
							emit_error(ERR_NAME_LONG);
						end
					end else begin
						emit_name();
						idle_byte(c);
					end
				end
				SM_NUMBER: begin
					if (is_num(c)) begin
						if (digit_cnt < MAX_NUMBER_DIGITS_DEF) begin
							num_acc = num_acc * 10 + (c - "0");
							digit_cnt++;
						end else begin
							emit_error(ERR_NUM_LONG);
						end
					end else begin
						emit_number();
						idle_byte(c);
					end
				end
				SM_SLASH: begin
					if (c == "/") begin
						scan_state = SM_LINE;
					end else if (c == "*") begin
						scan_state = SM_BLOCK;
					end else begin
						emit_code(TOK_SLASH);
						idle_byte(c);
					end
				end
				SM_LINE: begin
					if (c == CH_NL) begin
						scan_state = SM_IDLE;
					end
				end
				SM_BLOCK: begin
					if (c == "*") begin
						scan_state = SM_BLOCK_STAR;
					end
				end
				SM_BLOCK_STAR: begin
					if (c == "/") begin
						scan_state = SM_IDLE;
					end else if (c != "*") begin
						scan_state = SM_BLOCK;
					end
				end
				SM_LESS: begin
					if (c == ">") begin
						emit_code(TOK_NEQ);
						scan_state = SM_IDLE;
					end else if (c == "=") begin
						emit_code(TOK_LEQ);
						scan_state = SM_IDLE;
					end else begin
						emit_code(TOK_LSS);
						idle_byte(c);
					end
				end
				SM_GREATER: begin
					if (c == "=") begin
						emit_code(TOK_GEQ);
						scan_state = SM_IDLE;
					end else begin
						emit_code(TOK_GTR);
						idle_byte(c);
					end
				end
				SM_COLON: begin
					if (c == "=") begin
						emit_code(TOK_BECOMES);
						scan_state = SM_IDLE;
					end else begin
						emit_error(ERR_COLON);
					end
				end
				default: idle_byte(c);
			endcase
		end
		if (step_out.size() != 0) begin
			r = step_out.pop_back();
			r.last = 1'b1;
			step_out.push_back(r);
			foreach (step_out[i]) begin
				want_tokens.push_back(step_out[i]);
			end
		end
	endtask

	// Source text builders.
	task automatic push_byte(input logic [7:0] c);
		text_item_t it;
		it.req = REQ_CHAR;
		it.ch = c;
		pending_bytes.push_back(it);
	endtask

	task automatic push_eot();
		text_item_t it;
		it.req = REQ_EOT;
		it.ch = 8'($urandom_range(0, 255));
		pending_bytes.push_back(it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	function automatic logic [7:0] pick_letter();
		int v;
		v = $urandom_range(0, 51);
		return (v < 26) ? 8'("a" + v) : 8'("A" + v - 26);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// Block comment body: any byte, but a star is never followed by a slash.
	task automatic push_block_body();
		logic [7:0] c;
		logic [7:0] prev;
		int         n;
		prev = 8'd0;
		n = $urandom_range(0, 6);
		repeat (n) begin
			c = 8'($urandom_range(0, 255));
			if (prev == "*" && c == "/") begin
				c = "x";
			end
			push_byte(c);
			prev = c;
		end
	endtask

	task automatic push_line_body();
		logic [7:0] c;
		int         n;
		n = $urandom_range(0, 6);
		repeat (n) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_NL) begin
				c = "x";
			end
			push_byte(c);
		end
	endtask

	// Whitespace or a closed comment between tokens.
	task automatic push_gap(input bit allow_comment);
		int sel;
		int n;
		sel = $urandom_range(0, 9);
		if (!allow_comment || sel < 6) begin
			n = $urandom_range(1, 3);
			repeat (n) push_byte(ws_set[$urandom_range(0, 5)]);
		end else if (sel < 8) begin
			push_text("//");
			push_line_body();
			push_byte(CH_NL);
		end else begin
			push_text("/*");
			push_block_body();
			push_text(($urandom_range(0, 1) == 0) ? "*/" : "**/");
		end
	endtask

	task automatic make_piece(output string s, output piece_kind_t kind);
		int sel;
		int n;
		sel = $urandom_range(0, 99);
		s = "";
		if (sel < 25) begin
			kind = PIECE_WORD;
			s = kw_text[$urandom_range(0, WORD_COUNT - 1)];
		end else if (sel < 50) begin
			kind = PIECE_NAME;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, MAX_NAME_CHARS_DEF)
				: $urandom_range(1, 6);
			s = $sformatf("%c", pick_letter());
			for (int i = 1; i < n; i++) begin
				s = $sformatf("%s%c", s,
					($urandom_range(0, 2) == 0) ? pick_digit() : pick_letter());
			end
		end else if (sel < 70) begin
			kind = PIECE_NUMBER;
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, MAX_NUMBER_DIGITS_DEF)
				: $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				s = $sformatf("%s%c", s, pick_digit());
			end
		end else begin
			kind = PIECE_SYMBOL;
			s = sym_text[$urandom_range(0, SYMBOL_COUNT - 1)];
		end
	endtask

	// One well-formed text: tokens with optional gaps, closed by end of text.
	task automatic push_program();
		string       s;
		string       prev_s;
		piece_kind_t kind;
		piece_kind_t prev_kind;
		bit          split;
		int          n;
		int          sel;
		prev_s = "";
		prev_kind = PIECE_SYMBOL;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			make_piece(s, kind);
			if (i == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					push_gap(1'b1);
				end
			end else begin
				// Keep adjacent names and numbers apart; a slash must not open a comment.
				split = ((prev_kind == PIECE_WORD || prev_kind == PIECE_NAME) &&
					(is_alpha(s[0]) || is_num(s[0]))) ||
					(prev_kind == PIECE_NUMBER && is_num(s[0])) || prev_s == "/";
				if (split || $urandom_range(0, 9) < 4) begin
					push_gap(prev_s != "/");
				end
			end
			push_text(s);
			prev_s = s;
			prev_kind = kind;
		end
		sel = $urandom_range(0, 19);
		if (sel < 14) begin
			push_eot();
		end else if (sel < 17) begin
			push_gap(prev_s != "/");
			push_eot();
		end else begin
			// Text that ends inside an open comment.
			if (prev_s == "/") begin
				push_byte(8'd32);
			end
			if (sel == 17) begin
				push_text("//");
				push_line_body();
			end else begin
				push_text("/*");
				push_block_body();
			end
			push_eot();
		end
	endtask

	// The one lexical error of the run, then items that the halted block drops.
	task automatic push_fault_tail();
		fault_kind_t fault;
		logic [7:0]  c;
		fault = fault_kind_t'($urandom_range(0, 3));
		case (fault)
			FAULT_LONG_NAME: begin
				push_byte(pick_letter());
				repeat (MAX_NAME_CHARS_DEF) begin
					push_byte(($urandom_range(0, 1) == 0) ? pick_digit() : pick_letter());
				end
			end
			FAULT_LONG_NUMBER: begin
				repeat (MAX_NUMBER_DIGITS_DEF + 1) push_byte(pick_digit());
			end
			FAULT_STRAY: begin
				if ($urandom_range(0, 1) == 0) begin
					push_text("ab");
				end
				do begin
					c = 8'($urandom_range(0, 255));
				end while (is_alpha(c) || is_num(c) || is_blank(c) || is_punct(c));
				push_byte(c);
			end
			default: begin
				push_byte(":");
				if ($urandom_range(0, 1) == 0) begin
					push_eot();
				end else begin
					do begin
						c = 8'($urandom_range(0, 255));
					end while (c == "=");
					push_byte(c);
				end
			end
		endcase
		repeat (8) begin
			if ($urandom_range(0, 1) == 0) begin
				push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_eot();
			end
		end
	endtask

	// Idling is off during every third stretch and in the calm tail.
	function automatic bit may_idle();
		return pending_bytes.size() >= CALM_TAIL && (run_cycle / 128) % 3 != 0;
	endfunction

	// Byte feeder: presents the oldest pending item and holds it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_req <= REQ_CHAR;
			drv_char <= 8'd0;
			feed_gap <= 0;
		end else if (!drv_valid || text_if.ready) begin
			if (feed_gap != 0) begin
				drv_valid <= 1'b0;
				feed_gap <= feed_gap - 1;
			end else if (may_idle() && $urandom_range(0, 5) == 0) begin
				drv_valid <= 1'b0;
				feed_gap <= $urandom_range(0, 4);
			end else if (pending_bytes.size() != 0) begin
				drv_valid <= 1'b1;
				drv_req <= pending_bytes[0].req;
				drv_char <= pending_bytes[0].ch;
				void'(pending_bytes.pop_front());
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Token sink: ready with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			sink_gap <= 0;
		end else if (sink_gap != 0) begin
			sink_ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (may_idle() && $urandom_range(0, 5) == 0) begin
			sink_ready <= 1'b0;
			sink_gap <= $urandom_range(0, 4);
		end else begin
			sink_ready <= 1'b1;
		end
	end

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, fname, want, got);
			end
		end
	endtask

	// Compares an accepted token item with the oldest expected one.
	task automatic check_token();
		token_rec_t want;
		if (want_tokens.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("%0t: unexpected token item, expected none, actual code %0d err %0d",
					$time, tok_if.token_code, tok_if.error_code);
			end
			return;
		end
		want = want_tokens.pop_front();
		check_field("token_code", 64'(want.code), 64'(tok_if.token_code));
		check_field("number_value", 64'(want.num), 64'(tok_if.number_value));
		check_field("name_head", want.head, tok_if.name_head);
		check_field("name_tail", 64'(want.tail), 64'(tok_if.name_tail));
		check_field("name_length", 64'(want.len), 64'(tok_if.name_length));
		check_field("error_code", 64'(want.err), 64'(tok_if.error_code));
		check_field("last_in_run", 64'(want.last), 64'(tok_if.last_in_run));
	endtask

	// Monitor: checks results and feeds every accepted item to the model.
	always @(posedge clk) begin
		if (arst_n) begin
			run_cycle <= run_cycle + 1;
			if (tok_if.valid && sink_ready) begin
				check_token();
			end
			if (text_if.valid && text_if.ready) begin
				scan_item(text_if.req_type, text_if.char_code);
			end
		end
	end

	// Watchdog: ends the run when no handshake happens for too long.
	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_if.valid && text_if.ready) || (tok_if.valid && sink_ready)) begin
				stale = 0;
			end else begin
				stale++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int directed_cnt;
		// Longest name, largest number, number then letter, a pair, end of text.
		push_text("Zabcdefghi9");
		push_byte(8'd32);
		push_text("99999");
		push_byte(8'd32);
		push_text("7q<>");
		push_eot();
		// End of text inside a comment that holds the extreme bytes.
		push_text("/*");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_eot();
		directed_cnt = pending_bytes.size();
		while (pending_bytes.size() < directed_cnt + TEXT_ITEMS) begin
			push_program();
		end
		push_fault_tail();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || drv_valid) begin
			@(posedge clk);
		end
		while (want_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
